// ===== sv/maf_pkg.sv =====
// Shared types and codes for the MAC address allow/deny filter.
// Used by maf_cell and mac_allow_deny_filter; no dependencies.
package maf_pkg;

   localparam int TableDepthDefault = 64;
   localparam int AddrWidth         = 48;

   // actions
   localparam logic [1:0] ACT_CHECK  = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   // filter modes; the spare code filters nothing, like off
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_ALLOW = 2'd1;
   localparam logic [1:0] MODE_DENY  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // result status
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // command token walking down the cell chain
   typedef struct packed {
      logic                 active;
      logic [1:0]           action;
      logic [AddrWidth-1:0] addr;
      logic                 hit;    // match seen, or entry already claimed/removed
   } token_type;

endpackage

// ===== sv/maf_cell.sv =====
// One table entry of the filter: address, valid bit and one token stage.
// Depends on maf_pkg.
module maf_cell
   import maf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_up,
   output token_type tok_dn
);

   logic [AddrWidth-1:0] addr_ff;
   logic [AddrWidth-1:0] addr_in;
   logic                 valid_ff;
   logic                 valid_in;
   token_type            tok_dn_ff;
   token_type            tok_dn_in;
   logic                 match;

   assign match  = valid_ff && (addr_ff == tok_up.addr);
   assign tok_dn = tok_dn_ff;

   always_comb begin
      addr_in   = addr_ff;
      valid_in  = valid_ff;
      tok_dn_in = tok_up;
      if (tok_up.active) begin
         case (tok_up.action)
            ACT_CHECK: begin
               if (match) tok_dn_in.hit = 1'b1;
            end
            ACT_ADD: begin
               // first free entry along the chain takes the address
               if (!tok_up.hit && !valid_ff) begin
                  addr_in       = tok_up.addr;
                  valid_in      = 1'b1;
                  tok_dn_in.hit = 1'b1;
               end
            end
            ACT_DELETE: begin
               if (!tok_up.hit && match) begin
                  valid_in      = 1'b0;
                  tok_dn_in.hit = 1'b1;
               end
            end
            ACT_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         tok_dn_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         tok_dn_ff <= tok_dn_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

endmodule

// ===== sv/mac_allow_deny_filter.sv =====
// MAC address allow/deny filter: top level with command port and cell chain.
// Depends on maf_pkg and maf_cell.
// The command token is registered at the top and crosses one table cell per cycle;
// the result is registered after the last cell.
// One command at a time: start is ignored while busy; busy drops as the result shows.
// Reset (synchronous): table empty, mode disabled; results cannot be stalled.
module mac_allow_deny_filter
   import maf_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_action,
   input  logic [AddrWidth-1:0] req_mac_addr,
   output logic                 rsp_valid,
   output logic                 rsp_reject,
   output logic [1:0]           rsp_status,
   input  logic                 csr_we,
   input  logic [1:0]           csr_wdata
);

   logic [1:0] mode_ff;
   logic       busy_ff;
   logic       busy_in;
   token_type  tok_ff;
   token_type  tok_in;
   logic       rsp_valid_ff;
   logic       rsp_reject_ff;
   logic       rsp_reject_in;
   logic [1:0] rsp_status_ff;
   logic [1:0] rsp_status_in;
   token_type  tok_chain [TABLE_DEPTH+1];
   token_type  tok_last;
   logic       accept;

   assign accept     = start && !busy_ff;
   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_reject = rsp_reject_ff;
   assign rsp_status = rsp_status_ff;

   assign tok_chain[0] = tok_ff;
   assign tok_last     = tok_chain[TABLE_DEPTH];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      maf_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_up (tok_chain[i]),
         .tok_dn (tok_chain[i+1])
      );
   end

   always_comb begin
      tok_in        = tok_ff;
      tok_in.active = accept;
      if (accept) begin
         tok_in.action = req_action;
         tok_in.addr   = req_mac_addr;
         tok_in.hit    = 1'b0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) busy_in = 1'b1;
      else if (tok_last.active) busy_in = 1'b0;
   end

   always_comb begin
      rsp_reject_in = 1'b0;
      rsp_status_in = ST_OK;
      case (tok_last.action)
         ACT_CHECK: begin
            if (mode_ff == MODE_ALLOW) rsp_reject_in = !tok_last.hit;
            else if (mode_ff == MODE_DENY) rsp_reject_in = tok_last.hit;
         end
         ACT_ADD: begin
            if (!tok_last.hit) rsp_status_in = ST_FULL;
         end
         ACT_DELETE: begin
            if (!tok_last.hit) rsp_status_in = ST_NOT_FOUND;
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         busy_ff      <= 1'b0;
         tok_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) mode_ff <= csr_wdata;
         busy_ff      <= busy_in;
         tok_ff       <= tok_in;
         rsp_valid_ff <= tok_last.active;
      end
   end

   always_ff @(posedge clock) begin
      rsp_reject_ff <= rsp_reject_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
